// ===== rtl/core/lrfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_pkg
// Types, codes and helpers shared by the log record frame checker.
// ----------------------------------------------------------------------------
package lrfc_pkg;

  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned CHECK_BYTES     = 4;
  localparam int unsigned LRFC_QUEUE_DEPTH = 2;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;

  localparam logic [31:0] MAGIC_RST       = 32'd0;
  localparam logic [15:0] VERSION_RST     = 16'd1;
  localparam logic [7:0]  PUT_RST         = 8'd1;
  localparam logic [7:0]  DELETE_RST      = 8'd2;
  localparam logic [31:0] MAX_KEY_RST     = 32'd1024;
  localparam logic [31:0] MAX_VALUE_RST   = 32'd65536;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EOS   = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_NONE  = 2'd3
  } in_kind_e;

  typedef enum logic [1:0] {
    RK_PAYLOAD = 2'd0,
    RK_ACCEPT  = 2'd1,
    RK_FINISH  = 2'd2
  } result_kind_e;

  typedef enum logic [3:0] {
    ISS_NONE       = 4'd0,
    ISS_INCOMPLETE = 4'd1,
    ISS_MAGIC      = 4'd2,
    ISS_VERSION    = 4'd3,
    ISS_OPERATION  = 4'd4,
    ISS_LENGTH     = 4'd5,
    ISS_DELETE     = 4'd6,
    ISS_CHECKSUM   = 4'd7,
    ISS_IO         = 4'd8
  } issue_e;

  typedef enum logic [2:0] {
    CFG_MAGIC     = 3'd0,
    CFG_VERSION   = 3'd1,
    CFG_PUT       = 3'd2,
    CFG_DELETE    = 3'd3,
    CFG_MAX_KEY   = 3'd4,
    CFG_MAX_VALUE = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2,
    PH_HALT    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_EOS   = 2'd1,
    OP_ERROR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        in_value_part;
    logic        is_delete;
    logic [3:0]  issue;
    logic [63:0] position;
    logic [63:0] records_done;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] format_version;
    logic [7:0]  put_code;
    logic [7:0]  delete_code;
    logic [31:0] max_key_length;
    logic [31:0] max_value_length;
  } cfg_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/lrfc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_front
// Accepts stream items, drops unused kinds and turns the rest into commands.
// ----------------------------------------------------------------------------
module lrfc_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrfc_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output lrfc_pkg::cmd_t    cmd_o
);
  import lrfc_pkg::*;

  in_kind_e kind;

  assign kind       = in_kind_e'(in_item_i.kind);
  assign in_ready_o = cmd_ready_i;

  always_comb begin
    cmd_o.data_byte = in_item_i.data_byte;
    cmd_valid_o     = in_valid_i;
    case (kind)
      KIND_DATA:  cmd_o.op = OP_DATA;
      KIND_EOS:   cmd_o.op = OP_EOS;
      KIND_ERROR: cmd_o.op = OP_ERROR;
      default: begin
        cmd_o.op    = OP_DATA;
        cmd_valid_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/lrfc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module lrfc_queue #(
  parameter int unsigned Depth = lrfc_pkg::LRFC_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lrfc_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lrfc_pkg::cmd_t pop_cmd_o
);
  import lrfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/core/lrfc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_back
// Record checker: header store, CRC, counters and the registered result.
// ----------------------------------------------------------------------------
module lrfc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrfc_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  lrfc_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lrfc_pkg::out_item_t out_item_o
);
  import lrfc_pkg::*;

  localparam logic [3:0]  HdrLast = 4'(HEADER_BYTES - 1);
  localparam logic [1:0]  ChkLast = 2'(CHECK_BYTES - 1);
  localparam logic [33:0] Frame   = 34'(HEADER_BYTES + CHECK_BYTES);

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q [HEADER_BYTES];
  logic [32:0] cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d, rcrc_q, rcrc_d;
  logic [63:0] recs_q, recs_d, vb_q, vb_d;
  logic [32:0] total_q;
  logic [33:0] reclen_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, res;
  logic        emit;

  logic        fire;
  logic [7:0]  b;
  logic [31:0] crc_nx, key_len, val_in, rcrc_full;
  issue_e      hdr_iss;
  logic        is_del, hdr_done, pay_last, chk_done, crc_bad;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign b           = cmd_i.data_byte;
  assign crc_nx      = crc32_byte(crc_q, b);
  assign key_len     = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
  assign val_in      = {b, hdr_q[14], hdr_q[13], hdr_q[12]};
  assign is_del      = (hdr_q[6] != cfg_i.put_code);
  assign hdr_done    = (cnt_q[3:0] == HdrLast);
  assign pay_last    = ((cnt_q + 33'd1) >= total_q);
  assign chk_done    = (cnt_q[1:0] == ChkLast);
  assign rcrc_full   = {b, rcrc_q[23:0]};
  assign crc_bad     = ((~crc_q) != rcrc_full);

  always_comb begin
    if ({hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]} != cfg_i.magic_word) begin
      hdr_iss = ISS_MAGIC;
    end else if ({hdr_q[5], hdr_q[4]} != cfg_i.format_version) begin
      hdr_iss = ISS_VERSION;
    end else if (hdr_q[6] != cfg_i.put_code && hdr_q[6] != cfg_i.delete_code) begin
      hdr_iss = ISS_OPERATION;
    end else if (hdr_q[7] != 8'd0) begin
      hdr_iss = ISS_LENGTH;
    end else if (key_len == 32'd0 || key_len > cfg_i.max_key_length ||
                 val_in > cfg_i.max_value_length) begin
      hdr_iss = ISS_LENGTH;
    end else if (is_del && val_in != 32'd0) begin
      hdr_iss = ISS_DELETE;
    end else begin
      hdr_iss = ISS_NONE;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (fire && phase_q != PH_HALT) begin
      if (cmd_i.op != OP_DATA) begin
        phase_d = PH_HALT;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (hdr_done) begin
              phase_d = (hdr_iss != ISS_NONE) ? PH_HALT : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (pay_last) begin
              phase_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (chk_done) begin
              phase_d = crc_bad ? PH_HALT : PH_HEADER;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    rcrc_d = rcrc_q;
    recs_d = recs_q;
    vb_d   = vb_q;
    emit   = 1'b0;
    res    = '0;
    res.position     = vb_q;
    res.records_done = recs_q;
    if (fire && phase_q != PH_HALT) begin
      case (cmd_i.op)
        OP_EOS: begin
          emit            = 1'b1;
          res.result_kind = RK_FINISH;
          res.issue       = (phase_q == PH_HEADER && cnt_q == '0) ? ISS_NONE
                                                                  : ISS_INCOMPLETE;
        end
        OP_ERROR: begin
          emit            = 1'b1;
          res.result_kind = RK_FINISH;
          res.issue       = ISS_IO;
        end
        OP_DATA: begin
          case (phase_q)
            PH_HEADER: begin
              crc_d = crc_nx;
              cnt_d = hdr_done ? '0 : cnt_q + 33'd1;
              if (hdr_done && hdr_iss != ISS_NONE) begin
                emit            = 1'b1;
                res.result_kind = RK_FINISH;
                res.issue       = hdr_iss;
              end
            end
            PH_PAYLOAD: begin
              crc_d             = crc_nx;
              cnt_d             = pay_last ? '0 : cnt_q + 33'd1;
              emit              = 1'b1;
              res.result_kind   = RK_PAYLOAD;
              res.payload_byte  = b;
              res.in_value_part = (cnt_q >= {1'b0, key_len});
              res.is_delete     = is_del;
            end
            PH_CHECK: begin
              rcrc_d = rcrc_q | ({24'h0, b} << {cnt_q[1:0], 3'b000});
              cnt_d  = cnt_q + 33'd1;
              if (chk_done) begin
                emit = 1'b1;
                if (crc_bad) begin
                  res.result_kind = RK_FINISH;
                  res.issue       = ISS_CHECKSUM;
                end else begin
                  recs_d           = recs_q + 64'd1;
                  vb_d             = vb_q + {30'h0, reclen_q};
                  cnt_d            = '0;
                  crc_d            = '1;
                  rcrc_d           = '0;
                  res.result_kind  = RK_ACCEPT;
                  res.is_delete    = is_del;
                  res.position     = vb_d;
                  res.records_done = recs_d;
                end
              end
            end
            default: emit = 1'b0;
          endcase
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cnt_q       <= '0;
      crc_q       <= '1;
      rcrc_q      <= '0;
      recs_q      <= '0;
      vb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      rcrc_q      <= rcrc_d;
      recs_q      <= recs_d;
      vb_q        <= vb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && phase_q == PH_HEADER && cmd_i.op == OP_DATA) begin
      hdr_q[cnt_q[3:0]] <= b;
      if (hdr_done) begin
        total_q  <= {1'b0, key_len} + {1'b0, val_in};
        reclen_q <= {2'b0, key_len} + {2'b0, val_in} + Frame;
      end
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/log_record_frame_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_frame_checker_core
// Checks length-prefixed log records with a CRC-32 trailer, one byte per item.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled (bytewise CRC).
// Path: an accepted item is written into the queue, then the back part pops it
//   and loads the output register; a stalled output can hold it in the queue.
// Reset: configuration returns to its defaults, the checker waits for a header
//   at offset zero with counters cleared; after a final result it halts.
module log_record_frame_checker_core #(
  parameter int unsigned QueueDepth = lrfc_pkg::LRFC_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lrfc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lrfc_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import lrfc_pkg::*;

  cfg_t cfg_q;
  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word       <= MAGIC_RST;
      cfg_q.format_version   <= VERSION_RST;
      cfg_q.put_code         <= PUT_RST;
      cfg_q.delete_code      <= DELETE_RST;
      cfg_q.max_key_length   <= MAX_KEY_RST;
      cfg_q.max_value_length <= MAX_VALUE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAGIC:     cfg_q.magic_word       <= cfg_data_i;
        CFG_VERSION:   cfg_q.format_version   <= cfg_data_i[15:0];
        CFG_PUT:       cfg_q.put_code         <= cfg_data_i[7:0];
        CFG_DELETE:    cfg_q.delete_code      <= cfg_data_i[7:0];
        CFG_MAX_KEY:   cfg_q.max_key_length   <= cfg_data_i;
        CFG_MAX_VALUE: cfg_q.max_value_length <= cfg_data_i;
        default:       cfg_q                  <= cfg_q;
      endcase
    end
  end

  lrfc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  lrfc_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_cmd_i  (f_cmd),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready),
    .pop_cmd_o   (b_cmd)
  );

  lrfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(b_valid),
    .cmd_ready_o(b_ready),
    .cmd_i      (b_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  a_payload_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == RK_PAYLOAD |-> out_item_o.issue == ISS_NONE)
    else $error("payload item carries an issue");

  a_accept_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == RK_ACCEPT |->
      out_item_o.records_done != 64'd0 && out_item_o.issue == ISS_NONE)
    else $error("accepted record without count");

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.result_kind != 2'd3)
    else $error("unknown result kind");

endmodule

// ===== sim/log_record_frame_checker_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_frame_checker_core_tb
// Self-checking bench for the log record frame checker. Builds framed record
// streams (good and corrupted) under several register settings, predicts every
// forwarded byte, record acceptance and final scan result, and compares them
// with the block's output under random source idling and sink stalls.
// ----------------------------------------------------------------------------
module log_record_frame_checker_core_tb;
  import lrfc_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_item;
  out_item_t out_item;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;

  log_record_frame_checker_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor state
  cfg_t      cfg;
  phase_e    ph;
  logic [7:0]  hdr [16];
  logic [32:0] ph_cnt;
  logic [31:0] crc_run, crc_rx;
  logic [63:0] rec_cnt, byte_cnt;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int n_sent, n_got, n_mismatch;
  int src_idle_pct, snk_stall_pct;
  longint cycles;
  logic [31:0] gcrc;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    c ^= {24'h0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  function automatic logic [31:0] hdr32(int at);
    return {hdr[at+3], hdr[at+2], hdr[at+1], hdr[at]};
  endfunction

  function automatic issue_e header_issue();
    logic del;
    if (hdr32(0) != cfg.magic_word) return ISS_MAGIC;
    if ({hdr[5], hdr[4]} != cfg.format_version) return ISS_VERSION;
    if (hdr[6] == cfg.put_code) del = 1'b0;
    else if (hdr[6] == cfg.delete_code) del = 1'b1;
    else return ISS_OPERATION;
    if (hdr[7] != 8'd0) return ISS_LENGTH;
    if (hdr32(8) == 0 || hdr32(8) > cfg.max_key_length
        || hdr32(12) > cfg.max_value_length) return ISS_LENGTH;
    if (del && hdr32(12) != 0) return ISS_DELETE;
    return ISS_NONE;
  endfunction

  task automatic push_result(result_kind_e rk, logic [7:0] pb, logic iv, logic del,
                             issue_e iss);
    out_item_t r;
    r.result_kind = rk; r.payload_byte = pb; r.in_value_part = iv;
    r.is_delete = del; r.issue = iss; r.position = byte_cnt; r.records_done = rec_cnt;
    expected_results.push_back(r);
  endtask

  task automatic new_record();
    ph = PH_HEADER; ph_cnt = '0; crc_run = '1; crc_rx = '0;
  endtask

  task automatic finish_scan(issue_e iss);
    ph = PH_HALT;
    push_result(RK_FINISH, 8'd0, 1'b0, 1'b0, iss);
  endtask

  task automatic predict(in_item_t it);
    issue_e iss;
    logic [32:0] klen, total;
    logic iv, del;
    if (ph == PH_HALT || it.kind == KIND_NONE) return;
    if (it.kind == KIND_EOS) begin
      finish_scan((ph == PH_HEADER && ph_cnt == 0) ? ISS_NONE : ISS_INCOMPLETE);
      return;
    end
    if (it.kind == KIND_ERROR) begin
      finish_scan(ISS_IO);
      return;
    end
    del = (hdr[6] != cfg.put_code);
    case (ph)
      PH_HEADER: begin
        hdr[ph_cnt[3:0]] = it.data_byte;
        crc_run = crc_step(crc_run, it.data_byte);
        ph_cnt++;
        if (ph_cnt >= 16) begin
          iss = header_issue();
          if (iss != ISS_NONE) finish_scan(iss);
          else begin
            ph = PH_PAYLOAD; ph_cnt = '0;
          end
        end
      end
      PH_PAYLOAD: begin
        klen = {1'b0, hdr32(8)};
        total = klen + {1'b0, hdr32(12)};
        iv = (ph_cnt >= klen);
        crc_run = crc_step(crc_run, it.data_byte);
        ph_cnt++;
        if (ph_cnt >= total) begin
          ph = PH_CHECK; ph_cnt = '0;
        end
        push_result(RK_PAYLOAD, it.data_byte, iv, del, ISS_NONE);
      end
      default: begin
        crc_rx |= {24'h0, it.data_byte} << (8 * ph_cnt[1:0]);
        ph_cnt++;
        if (ph_cnt >= 4) begin
          if (~crc_run != crc_rx) finish_scan(ISS_CHECKSUM);
          else begin
            rec_cnt++;
            byte_cnt += 64'd20 + hdr32(8) + hdr32(12);
            new_record();
            push_result(RK_ACCEPT, 8'd0, 1'b0, del, ISS_NONE);
          end
        end
      end
    endcase
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict(in_item);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_got++;
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result %p", out_item);
        end else if (out_item !== expected_results[0]) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected %p actual %p", expected_results[0], out_item);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus builders
  task automatic add_byte(logic [7:0] b);
    in_item_t it;
    it.kind = KIND_DATA; it.data_byte = b;
    pending_items.push_back(it);
    gcrc = crc_step(gcrc, b);
  endtask

  task automatic add_event(in_kind_e k);
    in_item_t it;
    it.kind = k; it.data_byte = 8'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic add_le32(logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endtask

  // Builds one record; flaw picks a corruption: 0 none, 1 magic, 2 version,
  // 3 op, 4 pad byte, 5 key length, 6 delete with value, 7 crc, 8 truncation.
  task automatic add_record(int flaw, logic is_del, int klen, int vlen);
    logic [7:0] op;
    logic [31:0] c;
    int stop;
    gcrc = '1;
    stop = (flaw == 8) ? $urandom_range(1, 16 + klen + vlen + 3) : -1;
    op = is_del ? cfg.delete_code : cfg.put_code;
    if (flaw == 6) begin
      op = cfg.delete_code;
      if (vlen == 0) vlen = 1;
    end
    if (flaw == 3) op = cfg.put_code + 8'd1 + 8'($urandom_range(0, 100));
    if (flaw == 3 && (op == cfg.delete_code)) op++;
    if (flaw == 3 && (op == cfg.put_code)) op++;
    add_le32(flaw == 1 ? cfg.magic_word ^ (32'd1 << $urandom_range(31)) : cfg.magic_word);
    begin
      logic [15:0] v;
      v = (flaw == 2) ? cfg.format_version ^ (16'd1 << $urandom_range(15))
                      : cfg.format_version;
      add_byte(v[7:0]); add_byte(v[15:8]);
    end
    add_byte(op);
    add_byte(flaw == 4 ? 8'($urandom_range(1, 255)) : 8'd0);
    add_le32(flaw == 5 ? (($urandom_range(1) == 0) ? 32'd0 : cfg.max_key_length + 1)
                       : 32'(klen));
    add_le32(32'(vlen));
    if (flaw < 1 || flaw > 6) begin
      for (int i = 0; i < klen + vlen; i++) add_byte(8'($urandom));
      c = ~gcrc;
      if (flaw == 7) c ^= (32'd1 << $urandom_range(31));
      add_le32(c);
    end
    if (stop >= 0) begin
      while (pending_items.size() > 0 && stop > 0) begin
        void'(pending_items.pop_back());
        stop--;
      end
      add_event(KIND_EOS);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAGIC:     cfg.magic_word = val;
      CFG_VERSION:   cfg.format_version = val[15:0];
      CFG_PUT:       cfg.put_code = val[7:0];
      CFG_DELETE:    cfg.delete_code = val[7:0];
      CFG_MAX_KEY:   cfg.max_key_length = val;
      default:       cfg.max_value_length = val;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  int idle_set[4][2] = '{'{0, 0}, '{55, 0}, '{0, 55}, '{27, 27}};

  initial begin
    int flaw, kl, vl;
    rst_n = 1'b0; in_valid = 1'b0; in_item = '0; out_ready = 1'b0;
    cfg_we = 1'b0; cfg_idx = CFG_MAGIC; cfg_data = '0;
    n_sent = 0; n_got = 0; n_mismatch = 0; cycles = 0;
    src_idle_pct = 0; snk_stall_pct = 0;
    cfg = '{MAGIC_RST, VERSION_RST, PUT_RST, DELETE_RST, MAX_KEY_RST, MAX_VALUE_RST};
    for (int i = 0; i < 16; i++) hdr[i] = 8'd0;
    rec_cnt = '0; byte_cnt = '0;
    new_record();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default registers, unused kinds around a record
    add_event(KIND_NONE);
    add_record(0, 1'b0, 1, 2);
    add_event(KIND_NONE);
    drain();

    for (int s = 0; s < 12; s++) begin
      logic [31:0] mw;
      src_idle_pct = idle_set[s % 4][0];
      snk_stall_pct = idle_set[s % 4][1];
      // only directed-final records may end a scan; reset is one-shot, so the
      // first final result halts the block for the rest of the run.
      if (s == 0) begin
        mw = 32'hFFFFFFFF;
        write_reg(CFG_MAGIC, mw);
        write_reg(CFG_VERSION, 16'hFFFF);
        write_reg(CFG_PUT, 8'hFF);
        write_reg(CFG_DELETE, 8'h00);
        write_reg(CFG_MAX_KEY, 32'hFFFFFFFF);
        write_reg(CFG_MAX_VALUE, 32'hFFFFFFFF);
      end
      if (s >= 1 && s < 11) begin
        write_reg(CFG_MAGIC, $urandom);
        write_reg(CFG_VERSION, $urandom_range(65535));
        write_reg(CFG_PUT, $urandom_range(255));
        write_reg(CFG_DELETE, $urandom_range(255));
        write_reg(CFG_MAX_KEY, $urandom_range(1, 12));
        write_reg(CFG_MAX_VALUE, $urandom_range(0, 10));
      end
      repeat (1) begin
        kl = $urandom_range(1, cfg.max_key_length > 12 ? 12 : cfg.max_key_length);
        vl = $urandom_range(0, cfg.max_value_length > 10 ? 10 : cfg.max_value_length);
        if (cfg.put_code == cfg.delete_code) vl = vl;
        add_record(0, ($urandom_range(3) == 0) && (cfg.put_code != cfg.delete_code) ? 1'b1
                   : 1'b0, kl, 0);
        add_record(0, 1'b0, kl, vl);
      end
      drain();
    end
    // terminal: one of the final issues, chosen at random
    flaw = $urandom_range(1, 9);
    if (flaw == 9) begin
      add_record(0, 1'b0, 2, 3);
      add_event(KIND_ERROR);
    end else begin
      add_record(flaw, 1'b0, 2, 1);
    end
    add_record(0, 1'b0, 1, 1);
    add_event(KIND_EOS);
    drain();
    repeat (10) @(posedge clk);

    $display("sent %0d items, checked %0d results over 12 register settings", n_sent, n_got);
    $display("mismatches: %0d, left over: %0d", n_mismatch, expected_results.size());
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
